// ===== src/date_key_sort_and_cut_assert.svh =====
// ----------------------------------------------------------------------------
// date_key_sort_and_cut_assert.svh
// Assertion macros for the date key sort block; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef DATE_KEY_SORT_AND_CUT_ASSERT_SVH
`define DATE_KEY_SORT_AND_CUT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition implies another condition in the same cycle.
`define DKSC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("date_key_sort_and_cut: check failed");

// Check that a condition implies another condition in the next cycle.
`define DKSC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("date_key_sort_and_cut: check failed");

`else

`define DKSC_ASSERT_NOW(label, cond, prop)
`define DKSC_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ===== src/dksc_pkg.sv =====
// ----------------------------------------------------------------------------
// dksc_pkg
// Shared types, constants and helpers of the date key sort block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dksc_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int ID_W    = 10;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  localparam logic [YEAR_W-1:0] CUTOFF_RESET = YEAR_W'(2000);

  // One stored record.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the input word, or flag the drop when full
    logic sort_init;  // set up the first pass
    logic rd;         // read the store at the index
    logic take_cur;   // take the read word as the carried record
    logic cmp;        // compare carried and read records, write back the lower
    logic pass_end;   // write the carried record at the pass limit
    logic em_init;    // set up the emission sweep
    logic push_pend;  // hand the pending record to the output, not last
    logic accept_rd;  // take the read word as the pending record, advance
    logic push_last;  // hand the final word of the run to the output
    logic clr_run;    // clear count and drop flag for the next run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_one;
    logic idx_at_lim;
    logic lim_one;
    logic qual;
    logic pend_valid;
    logic out_free;
  } status_t;

  // Sort key: year, then month, then day.
  function automatic logic [KEY_W-1:0] date_key(input rec_t r);
    date_key = {r.year, r.month, r.day};
  endfunction

endpackage

// ===== src/date_key_sort_and_cut.sv =====
// Collects dated records one word per cycle until a word marked final, then
// sorts them stably by year, month and day and sends out, in that order,
// every record whose year is below cutoff_year; the last word of a run carries
// end_of_run, and a run with no such record gives one word with none_found.
// Records beyond the 64-entry store are dropped and reported in dropped. The
// store is a single-port memory with a registered read. A bubble pass writes
// back the lower of the carried and each read record, then the carried one
// at the pass limit; emission hands on the held record as each read one
// qualifies. Inputs are stalled from the final word until the run's last word
// is handed to the output register.
// ----------------------------------------------------------------------------
// date_key_sort_and_cut
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "date_key_sort_and_cut_assert.svh"

module date_key_sort_and_cut (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dksc_pkg::YEAR_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dksc_pkg::ID_W-1:0]    in_record_id,
  input  logic [dksc_pkg::DAY_W-1:0]   in_birth_day,
  input  logic [dksc_pkg::MONTH_W-1:0] in_birth_month,
  input  logic [dksc_pkg::YEAR_W-1:0]  in_birth_year,
  input  logic                         in_final_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dksc_pkg::ID_W-1:0]    out_id,
  output logic [dksc_pkg::DAY_W-1:0]   out_day,
  output logic [dksc_pkg::MONTH_W-1:0] out_month,
  output logic [dksc_pkg::YEAR_W-1:0]  out_year,
  output logic                         out_none_found,
  output logic                         out_dropped,
  output logic                         out_end_of_run
);
  import dksc_pkg::*;

  logic [YEAR_W-1:0] cutoff_r;
  cmd_t              cmd;
  status_t           sts;
  rec_t              in_rec;
  rec_t              out_rec;

  // Hold the cutoff year
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_we) begin
      cutoff_r <= cfg_wdata;
    end
  end

  assign in_rec.id    = in_record_id;
  assign in_rec.day   = in_birth_day;
  assign in_rec.month = in_birth_month;
  assign in_rec.year  = in_birth_year;

  dksc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_item (in_final_item),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  dksc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_rec    (in_rec),
    .cutoff    (cutoff_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec),
    .out_none  (out_none_found),
    .out_drop  (out_dropped),
    .out_eor   (out_end_of_run)
  );

  assign out_id    = out_rec.id;
  assign out_day   = out_rec.day;
  assign out_month = out_rec.month;
  assign out_year  = out_rec.year;

  // Checks
  `DKSC_ASSERT_NEXT(a_final_stalls, in_valid && !in_stall && in_final_item, in_stall)
  `DKSC_ASSERT_NOW(a_none_is_last, out_valid && out_none_found, out_end_of_run && out_year == '0)
  `DKSC_ASSERT_NOW(a_year_below_cut, out_valid && !out_none_found, out_year < cutoff_r)
  `DKSC_ASSERT_NOW(a_push_needs_room, cmd.push_pend || cmd.push_last, sts.out_free)

endmodule

// ===== src/dksc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dksc_ctrl
// Controller: load, bubble passes over the store, then emission of the cut.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dksc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_final_item,
  output logic             in_stall,
  input  dksc_pkg::status_t sts,
  output dksc_pkg::cmd_t    cmd
);
  import dksc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT    = 4'd1;
  localparam logic [3:0] ST_P_RD0   = 4'd2;
  localparam logic [3:0] ST_P_CUR   = 4'd3;
  localparam logic [3:0] ST_P_RD    = 4'd4;
  localparam logic [3:0] ST_P_CMP   = 4'd5;
  localparam logic [3:0] ST_P_END   = 4'd6;
  localparam logic [3:0] ST_EM_INIT = 4'd7;
  localparam logic [3:0] ST_EM_RD   = 4'd8;
  localparam logic [3:0] ST_EM_CHK  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final_item) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.sort_init = 1'b1;
        state_nxt = sts.cnt_one ? ST_EM_INIT : ST_P_RD0;
      end
      ST_P_RD0: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_P_CUR;
      end
      ST_P_CUR: begin
        cmd.take_cur = 1'b1;
        state_nxt    = ST_P_RD;
      end
      ST_P_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_P_CMP;
      end
      ST_P_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.idx_at_lim ? ST_P_END : ST_P_RD;
      end
      ST_P_END: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.lim_one ? ST_EM_INIT : ST_P_RD0;
      end
      ST_EM_INIT: begin
        cmd.em_init = 1'b1;
        state_nxt   = ST_EM_RD;
      end
      ST_EM_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EM_CHK;
      end
      ST_EM_CHK: begin
        // hold while a push is due and the output register cannot take a word
        if (sts.qual) begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.push_pend = sts.pend_valid;
            cmd.accept_rd = 1'b1;
            state_nxt     = ST_EM_RD;
          end
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          cmd.clr_run   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/dksc_dp.sv =====
// ----------------------------------------------------------------------------
// dksc_dp
// Datapath: record store, sort pointers, carried and pending records, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dksc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dksc_pkg::cmd_t               cmd,
  output dksc_pkg::status_t            sts,
  input  dksc_pkg::rec_t               in_rec,
  input  logic [dksc_pkg::YEAR_W-1:0]  cutoff,
  input  logic                         out_stall,
  output logic                         out_valid,
  output dksc_pkg::rec_t               out_rec,
  output logic                         out_none,
  output logic                         out_drop,
  output logic                         out_eor
);
  import dksc_pkg::*;

  rec_t mem [MAX_RECORDS];
  rec_t rdata_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              ovf_r;
  logic              ovf_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  idx_nxt;
  logic [ADDR_W-1:0] lim_r;
  logic [ADDR_W-1:0] lim_nxt;
  rec_t              cur_r;
  rec_t              cur_nxt;
  rec_t              pend_r;
  logic              pend_valid_r;
  logic              pend_valid_nxt;

  logic              out_valid_r;
  rec_t              out_rec_r;
  logic              out_none_r;
  logic              out_drop_r;
  logic              out_eor_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  rec_t              wdata;
  logic [CNT_W-1:0]  idx_m1;
  logic              swap;
  logic              store_full;
  logic              out_free;

  assign idx_m1     = idx_r - 1'b1;
  assign swap       = date_key(cur_r) > date_key(rdata_r);
  assign store_full = (count_r == CNT_W'(MAX_RECORDS));
  assign out_free   = !out_valid_r || !out_stall;

  // Store write port
  always_comb begin
    we    = 1'b0;
    waddr = count_r[ADDR_W-1:0];
    wdata = in_rec;
    if (cmd.load) begin
      we = !store_full;
    end else if (cmd.cmp) begin
      we    = 1'b1;
      waddr = idx_m1[ADDR_W-1:0];
      wdata = swap ? rdata_r : cur_r;
    end else if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = lim_r;
      wdata = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  // Counters, pointers and held records
  always_comb begin
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    cur_nxt        = cur_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd.load) begin
      if (store_full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.sort_init) begin
      idx_nxt = '0;
      lim_nxt = ADDR_W'(count_r - 1'b1);
    end
    if (cmd.take_cur) begin
      cur_nxt = rdata_r;
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.cmp) begin
      if (!swap) begin
        cur_nxt = rdata_r;
      end
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.pass_end) begin
      lim_nxt = lim_r - 1'b1;
      idx_nxt = '0;
    end
    if (cmd.em_init) begin
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.accept_rd) begin
      pend_valid_nxt = 1'b1;
      idx_nxt        = idx_r + 1'b1;
    end
    if (cmd.clr_run) begin
      count_nxt      = '0;
      ovf_nxt        = 1'b0;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    cur_r <= cur_nxt;
    if (cmd.accept_rd) begin
      pend_r <= rdata_r;
    end
  end

  // Output register: load on a push, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_pend || cmd.push_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pend) begin
      out_rec_r  <= pend_r;
      out_none_r <= 1'b0;
      out_drop_r <= ovf_r;
      out_eor_r  <= 1'b0;
    end else if (cmd.push_last) begin
      out_rec_r  <= pend_valid_r ? pend_r : '0;
      out_none_r <= !pend_valid_r;
      out_drop_r <= ovf_r;
      out_eor_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_none  = out_none_r;
  assign out_drop  = out_drop_r;
  assign out_eor   = out_eor_r;

  // Status back to the controller
  assign sts.cnt_one    = (count_r == CNT_W'(1));
  assign sts.idx_at_lim = (idx_r == CNT_W'(lim_r));
  assign sts.lim_one    = (lim_r == ADDR_W'(1));
  assign sts.qual       = (idx_r < count_r) && (rdata_r.year < cutoff);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

endmodule

// ===== tb/sv/date_key_sort_and_cut_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_key_sort_and_cut_tb
// Self-checking bench for the dated record sort and cutoff block.
// Queues runs of dated records: a handful of hand-picked edge cases first,
// then random runs. Most runs are short, and a few overflow the store. A
// behavioural sort predicts the words of each run, and the monitor checks every
// output word in order against that prediction. The cutoff year is changed
// between phases, and each phase uses its own mix of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------

module date_key_sort_and_cut_tb;
  import dksc_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;

  // One input word: a record plus its end-of-set mark.
  typedef struct packed {
    rec_t rec;
    logic last;
  } in_word_t;

  // One output word as the block presents it.
  typedef struct packed {
    rec_t rec;
    logic none_found;
    logic dropped;
    logic end_of_run;
  } out_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [YEAR_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ID_W-1:0]      in_record_id = '0;
  logic [DAY_W-1:0]     in_birth_day = '0;
  logic [MONTH_W-1:0]   in_birth_month = '0;
  logic [YEAR_W-1:0]    in_birth_year = '0;
  logic                 in_final_item = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_W-1:0]      out_id;
  logic [DAY_W-1:0]     out_day;
  logic [MONTH_W-1:0]   out_month;
  logic [YEAR_W-1:0]    out_year;
  logic                 out_none_found;
  logic                 out_dropped;
  logic                 out_end_of_run;

  // Stimulus and prediction state.
  in_word_t          pending_records[$];
  out_word_t         due_results[$];
  in_word_t          drive_word;
  rec_t              held[MAX_RECORDS];
  int                held_n = 0;
  logic              lost_flag = 1'b0;
  logic [YEAR_W-1:0] cutoff_shadow = CUTOFF_RESET;
  logic              in_taken = 1'b0;
  int                send_gap_pct = 0;
  int                recv_stall_pct = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  date_key_sort_and_cut u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_record_id   (in_record_id),
    .in_birth_day   (in_birth_day),
    .in_birth_month (in_birth_month),
    .in_birth_year  (in_birth_year),
    .in_final_item  (in_final_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_id         (out_id),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_none_found (out_none_found),
    .out_dropped    (out_dropped),
    .out_end_of_run (out_end_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Ordering key: year first, then month, then day.
  function automatic logic [YEAR_W+MONTH_W+DAY_W-1:0] order_key(input rec_t r);
    order_key = {r.year, r.month, r.day};
  endfunction

  // Store one accepted record; on the last of a set, sort and predict the run.
  task automatic file_record(input in_word_t w);
    int        i;
    int        j;
    int        nq;
    rec_t      tmp;
    out_word_t res;
    if (held_n < MAX_RECORDS) begin
      held[held_n] = w.rec;
      held_n++;
    end else begin
      lost_flag = 1'b1;
    end
    if (w.last) begin
      // stable insertion sort: equal keys keep arrival order
      for (i = 1; i < held_n; i++) begin
        tmp = held[i];
        j = i;
        while (j > 0 && order_key(held[j-1]) > order_key(tmp)) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = tmp;
      end
      nq = 0;
      while (nq < held_n && held[nq].year < cutoff_shadow) nq++;
      if (nq == 0) begin
        res = '0;
        res.none_found = 1'b1;
        res.dropped = lost_flag;
        res.end_of_run = 1'b1;
        due_results.push_back(res);
      end else begin
        for (i = 0; i < nq; i++) begin
          res.rec = held[i];
          res.none_found = 1'b0;
          res.dropped = lost_flag;
          res.end_of_run = (i == nq - 1);
          due_results.push_back(res);
        end
      end
      held_n = 0;
      lost_flag = 1'b0;
    end
  endtask

  // Drive inputs on the falling edge; advance only once the word was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_records.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          drive_word = pending_records.pop_front();
          in_valid <= 1'b1;
          in_record_id <= drive_word.rec.id;
          in_birth_day <= drive_word.rec.day;
          in_birth_month <= drive_word.rec.month;
          in_birth_year <= drive_word.rec.year;
          in_final_item <= drive_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Sample both channels on the rising edge; predict and check.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    in_word_t  acc;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        acc.rec.id = in_record_id;
        acc.rec.day = in_birth_day;
        acc.rec.month = in_birth_month;
        acc.rec.year = in_birth_year;
        acc.last = in_final_item;
        file_record(acc);
      end
      if (out_valid && !out_stall) begin
        got.rec.id = out_id;
        got.rec.day = out_day;
        got.rec.month = out_month;
        got.rec.year = out_year;
        got.none_found = out_none_found;
        got.dropped = out_dropped;
        got.end_of_run = out_end_of_run;
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected word: id=%0d d=%0d m=%0d y=%0d nf=%b dr=%b eor=%b",
                     $realtime, got.rec.id, got.rec.day, got.rec.month, got.rec.year,
                     got.none_found, got.dropped, got.end_of_run);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] mismatch: exp id=%0d d=%0d m=%0d y=%0d nf=%b dr=%b eor=%b",
                       $realtime, want.rec.id, want.rec.day, want.rec.month,
                       want.rec.year, want.none_found, want.dropped, want.end_of_run);
              $display("             got id=%0d d=%0d m=%0d y=%0d nf=%b dr=%b eor=%b",
                       got.rec.id, got.rec.day, got.rec.month, got.rec.year,
                       got.none_found, got.dropped, got.end_of_run);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long with work outstanding.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (pending_records.size() != 0 || due_results.size() != 0 || in_valid) begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
          $display("** date_key_sort_and_cut: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic push_record(input int id, input int day, input int month, input int year,
                             input bit last);
    in_word_t w;
    w.rec.id = ID_W'(id);
    w.rec.day = DAY_W'(day);
    w.rec.month = MONTH_W'(month);
    w.rec.year = YEAR_W'(year);
    w.last = last;
    pending_records.push_back(w);
  endtask

  // Queue one random run of n records; years cluster around the cutoff.
  task automatic queue_run(input int n);
    int i;
    int yr;
    int dy;
    int mo;
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        // repeat the previous date to exercise stability
      end else begin
        if ($urandom_range(1) == 0) begin
          yr = $urandom_range(4095);
        end else begin
          yr = int'(cutoff_shadow) + $urandom_range(16) - 8;
          if (yr < 0) yr = 0;
          if (yr > 4095) yr = 4095;
        end
        dy = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(31, 1);
        mo = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
      end
      push_record($urandom_range(1023), dy, mo, yr, i == n - 1);
    end
  endtask

  // Wait for every queued word to go in and every predicted word to come out.
  task automatic settle();
    while (pending_records.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [YEAR_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cutoff_shadow = value;
  endtask

  // One phase: new cutoff, new idling mix, random short runs and an optional big one.
  task automatic run_phase(input logic [YEAR_W-1:0] cut, input int gap, input int stall,
                           input int items, input int big);
    int queued;
    int n;
    settle();
    write_cutoff(cut);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    queued = 0;
    while (queued < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      queue_run(n);
      queued += n;
      if (big != 0 && queued >= items / 2) begin
        queue_run(big);
        big = 0;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-picked runs under the reset cutoff, no idling.
    push_record(1023, 31, 12, 4095, 0);  // id, day and year at their top
    push_record(0, 1, 1, 0, 0);          // earliest year
    push_record(5, 15, 6, 1999, 0);      // equal dates keep arrival order
    push_record(6, 15, 6, 1999, 0);
    push_record(7, 31, 1, 1990, 0);      // month outranks day
    push_record(8, 1, 2, 1990, 0);
    push_record(9, 0, 0, 1999, 0);       // day and month out of calendar range
    push_record(10, 31, 15, 1998, 0);
    push_record(11, 1, 1, 2000, 0);      // year equal to cutoff is held back
    push_record(12, 30, 12, 1999, 1);
    push_record(100, 7, 7, 2500, 1);     // nothing qualifies
    push_record(101, 7, 7, 1500, 1);     // single record run
    push_record(682, 21, 10, 1999, 0);   // alternating bit patterns, equal dates
    push_record(341, 21, 10, 1999, 1);

    // Random phases; the big runs fill the store exactly and overflow it.
    run_phase(YEAR_W'(0), 0, 0, 40, 0);
    run_phase(YEAR_W'(4095), 65, 0, 50, 64);
    run_phase(YEAR_W'(1990), 0, 65, 50, 65);
    run_phase(YEAR_W'($urandom_range(4095)), 17, 17, 50, 67);
    run_phase(YEAR_W'(1), 0, 0, 30, 0);
    run_phase(CUTOFF_RESET, 65, 65, 45, 0);

    settle();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("** date_key_sort_and_cut: PASSED **");
    end else begin
      $display("** date_key_sort_and_cut: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dksc_pkg.sv
src/dksc_ctrl.sv
src/dksc_dp.sv
src/date_key_sort_and_cut.sv
tb/sv/date_key_sort_and_cut_tb.sv
